@@ sv/mqttdf_pkg.sv @@
// Shared types and constants for the MQTT fixed-header deframer.
// No dependencies; imported by mqtt_fixed_header_deframer_unit.
package mqttdf_pkg;

   localparam int LEN_W            = 28;
   localparam int CNT_W            = 3;
   localparam int MAX_LEN_BYTES_DEF = 4;
   localparam int DIGIT_W          = 7;

   localparam logic [7:0] DIGIT_MASK = 8'd127;
   localparam logic [7:0] MORE_BIT   = 8'd128;
   localparam logic [7:0] TYPE_MASK  = 8'b11110000;
   localparam logic [7:0] FLAG_MASK  = 8'b00001111;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_LEN_TOO_LONG  = 2'd1,
      ERR_HDR_TRUNC     = 2'd2,
      ERR_PAYLOAD_TRUNC = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      PH_CONTROL = 4'b0001,
      PH_LENGTH  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_DISCARD = 4'b1000
   } phase_type;

endpackage

@@ sv/mqtt_fixed_header_deframer_unit.sv @@
// MQTT fixed-header deframer: control byte, remaining-length varint, payload.
// Depends on mqttdf_pkg.
//
// Usage:
//   Bytes of a received buffer enter on the req_ channel, one per beat, with
//   req_buffer_end high on the last byte of the buffer. The first byte is the
//   control byte, the next bytes the remaining length (base-128 varint, low
//   digit first). Once the length is complete one header beat leaves on the
//   rsp_ channel, followed by one beat per payload byte; rsp_packet_last marks
//   the final beat of a packet. Errors (too many length bytes, buffer ending in
//   the header, buffer ending before the payload is done) leave as one error
//   beat. Bytes after the payload are dropped up to the end of the buffer.
//   Throughput: one byte per cycle, also for bytes that give no result
//   (control, non-final length bytes, trailing bytes), while the receiver
//   does not stall. A result appears on rsp_ in the cycle after its byte is
//   accepted; the decode is one level of logic between the state registers
//   and the result register. Reset returns to waiting for a control byte and
//   empties the result register. When the receiver stalls, the result
//   register holds its beat and req_ready drops until that beat is taken.
module mqtt_fixed_header_deframer_unit #(
   parameter int MAX_LENGTH_BYTES = mqttdf_pkg::MAX_LEN_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        req_buffer_end,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_result_kind,
   output logic [3:0]                  rsp_packet_type,
   output logic [3:0]                  rsp_header_flags,
   output logic [mqttdf_pkg::LEN_W-1:0] rsp_remaining_length,
   output logic [7:0]                  rsp_payload_byte,
   output logic [1:0]                  rsp_error_code,
   output logic                        rsp_packet_last
);
   import mqttdf_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [7:0]              tf_ff, tf_in;
   logic [LEN_W-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [LEN_W-1:0]        left_ff, left_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                kind_ff, kind_in;
   err_type                 err_ff, err_in;
   logic [7:0]              tf_out_ff;
   logic [LEN_W-1:0]        len_out_ff;
   logic [7:0]              pbyte_ff, pbyte_in;
   logic                    last_ff, last_in;

   logic                    req_fire;
   logic                    res_valid;
   logic [LEN_W-1:0]        digit_shifted;
   logic [LEN_W-1:0]        acc_sum;
   logic [LEN_W-1:0]        left_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // place the 7-bit digit at its position in the length
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    digit_shifted = LEN_W'(req_rx_byte & DIGIT_MASK);
         2'd1:    digit_shifted = LEN_W'(req_rx_byte & DIGIT_MASK) << DIGIT_W;
         2'd2:    digit_shifted = LEN_W'(req_rx_byte & DIGIT_MASK) << (2 * DIGIT_W);
         default: digit_shifted = LEN_W'(req_rx_byte & DIGIT_MASK) << (3 * DIGIT_W);
      endcase
   end

   assign acc_sum  = acc_ff + digit_shifted;
   assign left_dec = left_ff - LEN_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      tf_in     = tf_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      res_valid = 1'b0;
      kind_in   = KIND_HEADER;
      err_in    = ERR_NONE;
      pbyte_in  = 8'd0;
      last_in   = 1'b0;
      case (phase_ff)
         PH_CONTROL: begin
            tf_in   = req_rx_byte;
            acc_in  = '0;
            cnt_in  = '0;
            left_in = '0;
            if (req_buffer_end) begin
               res_valid = 1'b1;
               kind_in   = KIND_ERROR;
               err_in    = ERR_HDR_TRUNC;
               last_in   = 1'b1;
            end else begin
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (cnt_ff >= CNT_W'(MAX_LENGTH_BYTES) || cnt_ff > CNT_W'(3)) begin
               res_valid = 1'b1;
               kind_in   = KIND_ERROR;
               err_in    = ERR_LEN_TOO_LONG;
               last_in   = 1'b1;
               phase_in  = req_buffer_end ? PH_CONTROL : PH_DISCARD;
            end else begin
               acc_in = acc_sum;
               cnt_in = cnt_ff + CNT_W'(1);
               if ((req_rx_byte & MORE_BIT) != 8'd0) begin
                  if (req_buffer_end) begin
                     res_valid = 1'b1;
                     kind_in   = KIND_ERROR;
                     err_in    = ERR_HDR_TRUNC;
                     last_in   = 1'b1;
                     phase_in  = PH_CONTROL;
                  end
               end else begin
                  left_in   = acc_sum;
                  res_valid = 1'b1;
                  if (acc_sum == '0) begin
                     last_in  = 1'b1;
                     phase_in = req_buffer_end ? PH_CONTROL : PH_DISCARD;
                  end else if (req_buffer_end) begin
                     kind_in  = KIND_ERROR;
                     err_in   = ERR_PAYLOAD_TRUNC;
                     last_in  = 1'b1;
                     phase_in = PH_CONTROL;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         PH_PAYLOAD: begin
            left_in   = left_dec;
            res_valid = 1'b1;
            pbyte_in  = req_rx_byte;
            if (left_dec == '0) begin
               kind_in  = KIND_PAYLOAD;
               last_in  = 1'b1;
               phase_in = req_buffer_end ? PH_CONTROL : PH_DISCARD;
            end else if (req_buffer_end) begin
               kind_in  = KIND_ERROR;
               err_in   = ERR_PAYLOAD_TRUNC;
               last_in  = 1'b1;
               phase_in = PH_CONTROL;
            end else begin
               kind_in = KIND_PAYLOAD;
            end
         end
         PH_DISCARD: begin
            // drop trailing bytes until the buffer ends
            if (req_buffer_end) begin
               phase_in = PH_CONTROL;
            end
         end
         default: begin
            phase_in = PH_CONTROL;
         end
      endcase
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CONTROL;
         tf_ff        <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff <= phase_in;
            tf_ff    <= tf_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
            left_ff  <= left_in;
         end
      end
   end

   // result register: load only with a beat that carries a result
   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         kind_ff    <= kind_in;
         err_ff     <= err_in;
         tf_out_ff  <= tf_in;
         len_out_ff <= acc_in;
         pbyte_ff   <= pbyte_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_packet_type      = 4'((tf_out_ff & TYPE_MASK) >> 4);
   assign rsp_header_flags     = 4'(tf_out_ff & FLAG_MASK);
   assign rsp_remaining_length = len_out_ff;
   assign rsp_payload_byte     = pbyte_ff;
   assign rsp_error_code       = err_ff;
   assign rsp_packet_last      = last_ff;

   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_LENGTH_BYTES))
      else $error("length byte count beyond limit");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ERROR |-> last_ff)
      else $error("error beat not marked last");

   a_mid_payload_stays: assert property (@(posedge clock) disable iff (reset)
      req_fire && res_valid && kind_in == KIND_PAYLOAD && !last_in
      |=> phase_ff == PH_PAYLOAD)
      else $error("left payload phase before last byte");

   a_no_result_in_discard: assert property (@(posedge clock) disable iff (reset)
      req_fire && (phase_ff == PH_DISCARD || phase_ff == PH_CONTROL) && !req_buffer_end
      |=> !rsp_valid_ff || $past(rsp_valid_ff))
      else $error("result produced by a byte that gives none");

endmodule
